// ===== design/idl_pkg.sv =====
// ----------------------------------------------------------------------------
// idl_pkg: shared types and constants of the indexed list
// Action and status codes, fixed field widths, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package idl_pkg;

   localparam int ActionW = 3;
   localparam int PosW    = 7;
   localparam int ValueW  = 32;
   localparam int CountW  = 7;
   localparam int StatusW = 2;

   typedef enum logic [ActionW-1:0] {
      ACT_INSERT = 3'd0,
      ACT_DELETE = 3'd1,
      ACT_SET    = 3'd2,
      ACT_GET    = 3'd3,
      ACT_CLEAR  = 3'd4
   } action_type;

   typedef enum logic [StatusW-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // request transfer this cycle
      logic step;     // high throughout the entry move loop
      logic commit;   // final move cycle: write the request value if needed
      logic rd_pos;   // read the entry at the request position
      logic load;     // load the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic go_move;  // accepted request needs the move loop
      logic go_read;  // accepted request is a valid get
      logic rem_zero; // no entries left to move
      logic pend;     // a moved entry still waits to be written
   } stat_type;

endpackage

// ===== design/idl_req_if.sv =====
// ----------------------------------------------------------------------------
// idl_req_if: request channel
// Valid/ready channel carrying one list action per transfer.
// ----------------------------------------------------------------------------
interface idl_req_if;
   logic                        valid;
   logic                        ready;
   logic [idl_pkg::ActionW-1:0] action;
   logic [idl_pkg::PosW-1:0]    position;
   logic [idl_pkg::ValueW-1:0]  value;

   modport source (output valid, output action, output position, output value,
                   input ready);
   modport sink   (input valid, input action, input position, input value,
                   output ready);
endinterface

// ===== design/idl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// idl_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface idl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [idl_pkg::ValueW-1:0]  read_value;
   logic [idl_pkg::CountW-1:0]  entry_count;
   logic [idl_pkg::StatusW-1:0] status;

   modport source (output valid, output read_value, output entry_count,
                   output status, input ready);
   modport sink   (input valid, input read_value, input entry_count,
                   input status, output ready);
endinterface

// ===== design/indexed_insert_delete_list_top.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_top: ordered list with insert and delete
// Bounded list of entries with a running count, driven by one action per
// request and answering each with one response.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. Each entry lives in a single RAM with
// one write and one registered read port, so insert and delete move the later
// entries one per cycle; the number moved is the count minus the position for
// insert and one less for delete. The response sits in an output register,
// so a new request is taken as soon as the response is loaded, even while
// that response still waits for its transfer. No clearing pass is needed
// after reset: only positions below the count are ever read.
module indexed_insert_delete_list_top #(
   parameter int LIST_DEPTH  = 64,
   parameter int ENTRY_WIDTH = 32
) (
   input logic      clock,
   input logic      reset,
   idl_req_if.sink  req_ch,
   idl_rsp_if.source rsp_ch
);

   import idl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   idl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   idl_dpath #(
      .LIST_DEPTH  (LIST_DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .action      (req_ch.action),
      .position    (req_ch.position),
      .value       (req_ch.value),
      .read_value  (rsp_ch.read_value),
      .entry_count (rsp_ch.entry_count),
      .status      (rsp_ch.status)
   );

endmodule

// ===== design/idl_ram.sv =====
// ----------------------------------------------------------------------------
// idl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered, held when idle.
// ----------------------------------------------------------------------------
module idl_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 64,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/idl_dpath.sv =====
// ----------------------------------------------------------------------------
// idl_dpath: list datapath
// Decodes requests against the entry count, holds the count, walks the entry
// store one entry a cycle for insert and delete, and builds the response.
// ----------------------------------------------------------------------------
module idl_dpath #(
   parameter int LIST_DEPTH  = 64,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  idl_pkg::cmd_type            cmd,
   output idl_pkg::stat_type           stat,
   input  logic [idl_pkg::ActionW-1:0] action,
   input  logic [idl_pkg::PosW-1:0]    position,
   input  logic [idl_pkg::ValueW-1:0]  value,
   output logic [idl_pkg::ValueW-1:0]  read_value,
   output logic [idl_pkg::CountW-1:0]  entry_count,
   output logic [idl_pkg::StatusW-1:0] status
);

   import idl_pkg::*;

   localparam int AddrW = $clog2(LIST_DEPTH);
   localparam int CntW  = $clog2(LIST_DEPTH + 1);
   localparam int CmpW  = (CntW > PosW) ? CntW : PosW;

   // request decode
   action_type       act;
   logic [CmpW-1:0]  pos_x;
   logic [CmpW-1:0]  cnt_x;
   logic             full;
   logic             in_range;
   status_type       dec_status;
   logic [CntW-1:0]  dec_count;
   logic [CntW-1:0]  dec_rem;
   logic [AddrW-1:0] dec_ptr;
   logic             dec_move;
   logic             dec_ins;
   logic             dec_wr;
   logic             dec_rd;
   logic [ENTRY_WIDTH+ValueW-1:0] val_ext;
   logic [ENTRY_WIDTH+ValueW-1:0] rd_ext;

   // held request and loop state
   logic [CntW-1:0]        count_ff, count_in;
   logic [AddrW-1:0]       pos_ff;
   logic [ENTRY_WIDTH-1:0] value_ff;
   status_type             status_ff;
   logic                   ins_ff, wr_ff, get_ff;
   logic [CntW-1:0]        rem_ff;
   logic [AddrW-1:0]       ptr_ff;
   logic [AddrW-1:0]       wdst_ff;
   logic                   pend_ff, pend_in;

   // response register
   logic [ValueW-1:0]  rd_out_ff;
   logic [CountW-1:0]  cnt_out_ff;
   logic [StatusW-1:0] st_out_ff;

   // RAM ports
   logic                   ram_wr_en;
   logic [AddrW-1:0]       ram_wr_addr;
   logic [ENTRY_WIDTH-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [AddrW-1:0]       ram_rd_addr;
   logic [ENTRY_WIDTH-1:0] ram_rd_data;

   assign act      = action_type'(action);
   assign pos_x    = CmpW'(position);
   assign cnt_x    = CmpW'(count_ff);
   assign full     = (count_ff == CntW'(LIST_DEPTH));
   assign in_range = (pos_x < cnt_x);
   assign val_ext  = {{ENTRY_WIDTH{1'b0}}, value};
   assign rd_ext   = {{ValueW{1'b0}}, ram_rd_data};

   always_comb begin
      dec_status = ST_DONE;
      dec_count  = count_ff;
      dec_rem    = '0;
      dec_ptr    = '0;
      dec_move   = 1'b0;
      dec_ins    = 1'b0;
      dec_wr     = 1'b0;
      dec_rd     = 1'b0;
      case (act)
         ACT_INSERT: begin
            // a bad position is reported ahead of a full list
            if (pos_x > cnt_x) begin
               dec_status = ST_RANGE;
            end else if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_move  = 1'b1;
               dec_ins   = 1'b1;
               dec_wr    = 1'b1;
               dec_count = count_ff + CntW'(1);
               dec_rem   = CntW'(cnt_x - pos_x);
               dec_ptr   = AddrW'(cnt_x - CmpW'(1));
            end
         end
         ACT_DELETE: begin
            if (!in_range) begin
               dec_status = ST_RANGE;
            end else begin
               dec_move  = 1'b1;
               dec_count = count_ff - CntW'(1);
               dec_rem   = CntW'(cnt_x - pos_x - CmpW'(1));
               dec_ptr   = AddrW'(pos_x + CmpW'(1));
            end
         end
         ACT_SET: begin
            if (!in_range) begin
               dec_status = ST_RANGE;
            end else begin
               dec_move = 1'b1;
               dec_wr   = 1'b1;
            end
         end
         ACT_GET: begin
            if (!in_range) begin
               dec_status = ST_RANGE;
            end else begin
               dec_rd = 1'b1;
            end
         end
         ACT_CLEAR: begin
            dec_count = '0;
         end
         default: begin
         end
      endcase
   end

   assign count_in = cmd.accept ? dec_count : count_ff;

   always_comb begin
      pend_in = pend_ff;
      if (cmd.accept) begin
         pend_in = 1'b0;
      end else if (cmd.step) begin
         pend_in = (rem_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pos_ff    <= pos_x[AddrW-1:0];
         value_ff  <= val_ext[ENTRY_WIDTH-1:0];
         status_ff <= dec_status;
         ins_ff    <= dec_ins;
         wr_ff     <= dec_wr;
         get_ff    <= dec_rd;
         rem_ff    <= dec_rem;
         ptr_ff    <= dec_ptr;
      end else if (cmd.step && (rem_ff != '0)) begin
         // insert walks down from the top, delete walks up
         wdst_ff <= ins_ff ? ptr_ff + AddrW'(1) : ptr_ff - AddrW'(1);
         ptr_ff  <= ins_ff ? ptr_ff - AddrW'(1) : ptr_ff + AddrW'(1);
         rem_ff  <= rem_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_out_ff  <= get_ff ? rd_ext[ValueW-1:0] : '0;
         cnt_out_ff <= CountW'(CmpW'(count_ff));
         st_out_ff  <= status_ff;
      end
   end

   // moved entry written the cycle after its read; commit only once the move
   // loop has drained, so the write port is free
   assign ram_wr_en   = (cmd.step && pend_ff) || (cmd.commit && wr_ff);
   assign ram_wr_addr = pend_ff ? wdst_ff : pos_ff;
   assign ram_wr_data = pend_ff ? ram_rd_data : value_ff;
   assign ram_rd_en   = (cmd.step && (rem_ff != '0)) || cmd.rd_pos;
   assign ram_rd_addr = cmd.rd_pos ? pos_ff : ptr_ff;

   idl_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign stat.go_move  = dec_move;
   assign stat.go_read  = dec_rd;
   assign stat.rem_zero = (rem_ff == '0);
   assign stat.pend     = pend_ff;

   assign read_value  = rd_out_ff;
   assign entry_count = cnt_out_ff;
   assign status      = st_out_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(LIST_DEPTH))
      else $error("entry count beyond list depth");

   a_pend_from_step : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(cmd.step))
      else $error("pending move write without a move step");

   a_commit_free_port : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !pend_ff)
      else $error("value commit collides with a moved entry write");

   a_delete_count : assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && dec_move && (act == ACT_DELETE))
      |=> (count_ff == $past(count_ff) - CntW'(1)))
      else $error("delete did not lower the count");

endmodule

// ===== design/idl_ctrl.sv =====
// ----------------------------------------------------------------------------
// idl_ctrl: list controller
// Sequences one request at a time through move, read and response phases and
// owns the request ready and response valid handshakes.
// ----------------------------------------------------------------------------
module idl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  idl_pkg::stat_type stat,
   output idl_pkg::cmd_type  cmd
);

   import idl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_MOVE   = 4'b0010,
      S_READ   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      move_done;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign move_done = stat.rem_zero && !stat.pend;

   assign cmd.accept = accept;
   assign cmd.step   = (state_ff == S_MOVE);
   assign cmd.commit = (state_ff == S_MOVE) && move_done;
   assign cmd.rd_pos = (state_ff == S_READ);
   // response register is free, or its transfer completes this cycle
   assign cmd.load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (stat.go_move) begin
                  state_in = S_MOVE;
               end else if (stat.go_read) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_MOVE: begin
            if (move_done) begin
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (cmd.load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("request transfer did not start work");

   a_move_drains : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == S_FINISH))
      else $error("move loop finished without going to response");

   a_load_gives_valid : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("response load lost");

endmodule
